/* design/clt_pkg.sv */
// Shared types and constants for the command line tokenizer.
package clt_pkg;

	localparam logic [10:0] MAX_TOKENS = 11'd1024;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		MODE_WS,
		MODE_WS_SLASH,
		MODE_TOKEN,
		MODE_TOKEN_SLASH,
		MODE_QUOTED,
		MODE_COMMENT,
		MODE_COMMENT_STAR,
		MODE_DONE
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [10:0] num;
	} result_t;

	// All results caused by one input byte; n counts the valid slots from 0.
	typedef struct packed {
		logic [1:0]         n;
		result_t [2:0]      res;
	} bundle_t;

	function automatic logic [10:0] idx_of(input logic [10:0] c);
		return (c == 11'd0) ? 11'd0 : c - 11'd1;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b inside {[8'd1:CH_SPACE]}) || b[7];
	endfunction

	function automatic result_t mk_res(input kind_t k, input logic [7:0] d,
			input logic [10:0] num);
		result_t r;
		r.kind = k;
		r.data = d;
		r.num  = num;
		return r;
	endfunction

endpackage

/* design/command_line_tokenizer_core.sv */
// Top level of the command line tokenizer: parser, bundle queue and result serializer.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | push / full       | in_byte
//  result   | pop / empty       | kind, out_byte, token_number, last
//
// One byte is taken per cycle while full is low; the parser decides all its
// results in that cycle and queues them as one bundle (bytes with no result
// add nothing). Results leave one per cycle while pop is high, so a byte with k
// results holds the result side for k pops; the four-bundle queue absorbs bursts.
// Reset clears the parse mode, token count, queue pointers and result slot.
module command_line_tokenizer_core import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [10:0] token_number,
	output logic        last
);

	logic    q_push, q_pop, q_full, q_empty;
	bundle_t in_bundle, head;

	assign full = q_full;

	clt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (push && !q_full),
		.in_byte (in_byte),
		.push    (q_push),
		.bundle  (in_bundle)
	);

	clt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (in_bundle),
		.pop    (q_pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	clt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.out_byte     (out_byte),
		.token_number (token_number),
		.last         (last)
	);

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> in_bundle.n != 2'd0)
		else $error("bundle with no results queued");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == KIND_BYTE || kind == KIND_TOKEN_END || kind == KIND_LINE_END))
		else $error("result kind out of range");

	a_mark_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_BYTE) |-> out_byte == 8'd0)
		else $error("mark carries a nonzero byte");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_LINE_END) |-> last)
		else $error("line end is not the last result of its byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(token_number)))
		else $error("waiting result changed before transfer");

endmodule

/* design/clt_front.sv */
// Front part: parse state machine that turns one byte into a bundle of results.
module clt_front import clt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	output logic       push,
	output bundle_t    bundle
);

	mode_t       mode_q, mode_d;
	logic [10:0] count_q, count_d;

	logic        is_nul, is_sp, is_q, is_sl, is_st;
	logic        lim_c, lim_t;
	logic [10:0] cs, ci_c, ci_s, ct, ci_t;
	logic        tb_ws_slash, tb_tslash, tb;

	assign is_nul = (in_byte == CH_NUL);
	assign is_sp  = is_space(in_byte);
	assign is_q   = (in_byte == CH_QUOTE);
	assign is_sl  = (in_byte == CH_SLASH);
	assign is_st  = (in_byte == CH_STAR);

	assign lim_c = (count_q >= MAX_TOKENS);
	assign cs    = lim_c ? count_q : count_q + 11'd1;
	assign ci_c  = idx_of(count_q);
	assign ci_s  = idx_of(cs);

	// A held slash that turns out not to open a comment falls back into token handling.
	assign tb_ws_slash = (mode_q == MODE_WS_SLASH) && !is_sl && !is_st;
	assign tb_tslash   = (mode_q == MODE_TOKEN_SLASH) && !is_sl && !is_st;
	assign tb          = tb_ws_slash || tb_tslash || (mode_q == MODE_TOKEN);
	assign ct          = tb_ws_slash ? cs : count_q;
	assign lim_t       = (ct >= MAX_TOKENS);
	assign ci_t        = idx_of(ct);

	// Next state
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		if (tb) begin
			if (is_nul) begin
				mode_d  = MODE_WS;
				count_d = 11'd0;
			end else if (is_sp) begin
				mode_d  = lim_t ? MODE_DONE : MODE_WS;
				count_d = ct;
			end else if (is_q) begin
				mode_d  = lim_t ? MODE_DONE : MODE_QUOTED;
				count_d = lim_t ? ct : ct + 11'd1;
			end else if (is_sl) begin
				mode_d  = MODE_TOKEN_SLASH;
				count_d = ct;
			end else begin
				mode_d  = MODE_TOKEN;
				count_d = ct;
			end
		end else if (is_nul && mode_q != MODE_WS_SLASH && mode_q != MODE_TOKEN_SLASH) begin
			mode_d  = MODE_WS;
			count_d = 11'd0;
		end else begin
			case (mode_q)
				MODE_WS: begin
					if (is_sl) begin
						mode_d = MODE_WS_SLASH;
					end else if (!is_sp) begin
						mode_d  = is_q ? MODE_QUOTED : MODE_TOKEN;
						count_d = cs;
					end
				end
				MODE_WS_SLASH: begin
					mode_d = is_sl ? MODE_DONE : MODE_COMMENT_STAR;
				end
				MODE_TOKEN_SLASH: begin
					if (is_sl)
						mode_d = MODE_DONE;
					else
						mode_d = lim_c ? MODE_DONE : MODE_COMMENT_STAR;
				end
				MODE_QUOTED: begin
					if (is_q)
						mode_d = lim_c ? MODE_DONE : MODE_WS;
				end
				MODE_COMMENT: begin
					if (is_st)
						mode_d = MODE_COMMENT_STAR;
				end
				MODE_COMMENT_STAR: begin
					if (is_sl)
						mode_d = MODE_WS;
					else if (!is_st)
						mode_d = MODE_COMMENT;
				end
				default: begin
				end
			endcase
		end
	end

	// Outputs
	always_comb begin
		logic [1:0] n;
		n = 2'd0;
		bundle.res = '0;
		if (tb) begin
			if (tb_ws_slash || tb_tslash) begin
				bundle.res[n] = mk_res(KIND_BYTE, CH_SLASH, ci_t);
				n = n + 2'd1;
			end
			if (is_nul) begin
				bundle.res[n] = mk_res(KIND_TOKEN_END, 8'd0, ci_t);
				n = n + 2'd1;
				bundle.res[n] = mk_res(KIND_LINE_END, 8'd0, ct);
				n = n + 2'd1;
			end else if (is_sp || is_q) begin
				bundle.res[n] = mk_res(KIND_TOKEN_END, 8'd0, ci_t);
				n = n + 2'd1;
			end else if (!is_sl) begin
				bundle.res[n] = mk_res(KIND_BYTE, in_byte, ci_t);
				n = n + 2'd1;
			end
		end else begin
			case (mode_q)
				MODE_WS: begin
					if (is_nul) begin
						bundle.res[0] = mk_res(KIND_LINE_END, 8'd0, count_q);
						n = 2'd1;
					end else if (!is_sp && !is_sl && !is_q) begin
						bundle.res[0] = mk_res(KIND_BYTE, in_byte, ci_s);
						n = 2'd1;
					end
				end
				MODE_TOKEN_SLASH: begin
					bundle.res[0] = mk_res(KIND_TOKEN_END, 8'd0, ci_c);
					n = 2'd1;
				end
				MODE_QUOTED: begin
					if (is_nul) begin
						bundle.res[0] = mk_res(KIND_TOKEN_END, 8'd0, ci_c);
						bundle.res[1] = mk_res(KIND_LINE_END, 8'd0, count_q);
						n = 2'd2;
					end else if (is_q) begin
						bundle.res[0] = mk_res(KIND_TOKEN_END, 8'd0, ci_c);
						n = 2'd1;
					end else begin
						bundle.res[0] = mk_res(KIND_BYTE, in_byte, ci_c);
						n = 2'd1;
					end
				end
				MODE_COMMENT, MODE_COMMENT_STAR, MODE_DONE: begin
					if (is_nul) begin
						bundle.res[0] = mk_res(KIND_LINE_END, 8'd0, count_q);
						n = 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
		bundle.n = n;
		push     = take && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WS;
			count_q <= 11'd0;
		end else if (take) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

endmodule

/* design/clt_queue.sv */
// Short bundle queue between the parser and the result serializer.
module clt_queue import clt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wdata,
	input  logic    pop,
	output bundle_t rdata,
	output logic    full,
	output logic    empty
);

	bundle_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push, do_pop;

	assign full    = (fill_q == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* design/clt_back.sv */
// Back part: hands the results of the head bundle out one per transfer.
module clt_back import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [10:0] token_number,
	output logic        last
);

	logic [1:0] sel_q;
	result_t    cur;

	assign cur          = head.res[sel_q];
	assign empty        = q_empty;
	assign kind         = cur.kind;
	assign out_byte     = cur.data;
	assign token_number = cur.num;
	assign last         = (sel_q == head.n - 2'd1);
	assign q_pop        = pop && !q_empty && last;

	// Advance through the bundle; drop it from the queue after its last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 2'd0;
		else if (pop && !q_empty)
			sel_q <= last ? 2'd0 : sel_q + 2'd1;
	end

endmodule
